// ----- hdl/ump_midi1_midi2_voice_converter_core_assert.svh -----
// assertion macros used by the converter checker
`ifndef UMP_MIDI1_MIDI2_VOICE_CONVERTER_CORE_ASSERT_SVH
`define UMP_MIDI1_MIDI2_VOICE_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define UMPVC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define UMPVC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/umpvc_pkg.sv -----
// shared types, codes and constants of the ump voice converter
package umpvc_pkg;

  localparam int DEF_MAX_PACKET_WORDS = 32;
  localparam int unsigned RESULT_LIMIT = 32;

  localparam logic [3:0] MT_UTILITY  = 4'h1;
  localparam logic [3:0] MT_M1_VOICE = 4'h2;
  localparam logic [3:0] MT_DATA64   = 4'h3;
  localparam logic [3:0] MT_M2_VOICE = 4'h4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_COUNT    = 3'd1,
    ST_TYPE     = 3'd2,
    ST_OPCODE   = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_HEAD,
    S_JUDGE,
    S_UP2,
    S_DRD,
    S_DOWN,
    S_PRD,
    S_POUT
  } state_t;

  typedef struct packed {
    logic        op_ok;
    logic [31:0] up_a;
    logic [31:0] up_b;
    logic [31:0] down_a;
  } xl_t;

endpackage

// ----- hdl/umpvc_if.sv -----
// request channels for packet words in and result words out
interface umpvc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] in_word;
  logic        in_last;

  modport source (output valid, output in_word, output in_last, input ready);
  modport sink (input valid, input in_word, input in_last, output ready);
endinterface

interface umpvc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        out_last;
  logic [2:0]  status;

  modport source (output valid, output out_word, output out_last, output status, input ready);
  modport sink (input valid, input out_word, input out_last, input status, output ready);
endinterface

// ----- hdl/umpvc_buf.sv -----
// packet word buffer: one write port, one registered read port
module umpvc_buf import umpvc_pkg::*; #(
  parameter int DEPTH = DEF_MAX_PACKET_WORDS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/umpvc_xlate.sv -----
// channel voice translation between midi 1.0 and midi 2.0 words
module umpvc_xlate import umpvc_pkg::*; (
  input  logic [31:0] w0,
  input  logic [31:0] w1,
  output xl_t         xl
);

  logic [3:0] group_f;
  logic [3:0] nib;
  logic [3:0] chan;
  logic [7:0] d1;
  logic [7:0] d2;
  logic [7:0] up_o1;
  logic [31:0] up_val;
  logic [7:0] dn_o1;
  logic [7:0] dn_o2;

  assign group_f = w0[27:24];
  assign nib     = w0[23:20];
  assign chan    = w0[19:16];
  assign d1      = w0[15:8];
  assign d2      = w0[7:0];

  always_comb begin
    up_o1  = 8'h00;
    up_val = 32'h0;
    dn_o1  = 8'h00;
    dn_o2  = 8'h00;
    unique case (nib)
      4'h8, 4'h9, 4'hA: begin
        up_o1  = {1'b0, d1[6:0]};
        up_val = {d2[6:0], 25'h0};
        dn_o1  = {1'b0, d1[6:0]};
        dn_o2  = {1'b0, w1[31:25]};
      end
      4'hB: begin
        up_o1  = d1;
        up_val = {d2[6:0], 25'h0};
        dn_o1  = d1;
        dn_o2  = {1'b0, w1[31:25]};
      end
      4'hC: begin
        up_o1  = {1'b0, d1[6:0]};
        up_val = {d1[6:0], 25'h0};
        dn_o1  = {1'b0, d1[6:0]};
      end
      4'hD: begin
        up_val = {d1[6:0], 25'h0};
        dn_o1  = {1'b0, w1[31:25]};
      end
      4'hE: begin
        // 14-bit bend: lsb 7 bits in d1, msb 7 bits in d2
        up_val = {d2[6:0], d1[6:0], 18'h0};
        dn_o1  = {1'b0, w1[24:18]};
        dn_o2  = {1'b0, w1[31:25]};
      end
      default: begin
        up_o1 = 8'h00;
      end
    endcase
  end

  assign xl.op_ok  = nib[3] && (nib != 4'hF);
  assign xl.up_a   = {MT_M2_VOICE, group_f, nib, chan, up_o1, 8'h00};
  assign xl.up_b   = up_val;
  assign xl.down_a = {MT_M1_VOICE, group_f, nib, chan, dn_o1, dn_o2};

endmodule

// ----- hdl/ump_midi1_midi2_voice_converter_core.sv -----
// top level of the ump voice converter: buffer, sequencer and output register
// words are taken one per cycle while a packet collects; the last word starts the answer
// first result is registered in judge after the head read (down: in down after word 1 is read)
// pass-through packets alternate read and output states per word at the buffer's single read port
// reset clears the sequencer, word count, overflow flag, direction and output valid
// the buffer itself is not cleared: only entries written in the current packet are read
module ump_midi1_midi2_voice_converter_core import umpvc_pkg::*; #(
  parameter int MAX_PACKET_WORDS = DEF_MAX_PACKET_WORDS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  umpvc_in_if.sink     in_chan,
  umpvc_out_if.source  out_chan
);

  localparam int AW = (MAX_PACKET_WORDS > 1) ? $clog2(MAX_PACKET_WORDS) : 1;
  localparam int CW = $clog2(MAX_PACKET_WORDS + 1);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] pkt_n, pkt_n_next;
  logic          pkt_ovf, pkt_ovf_next;
  logic [CW-1:0] idx, idx_next;
  logic [31:0]   w0_q, w0_next;
  logic          direction;

  logic          out_valid, out_valid_next;
  logic [31:0]   out_word, out_word_next;
  logic          out_last, out_last_next;
  status_t       out_status, out_status_next;

  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  logic [31:0]   xl_w0;
  xl_t           xl;

  logic          slot_free;
  logic          emit;
  logic [31:0]   e_word;
  logic          e_last;
  status_t       e_st;
  logic [3:0]    mt;
  logic          pass_last;

  umpvc_buf #(.DEPTH(MAX_PACKET_WORDS)) u_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[AW-1:0]),
    .wdata (in_chan.in_word),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // during down conversion the head word sits in w0_q and the read port holds word 1
  assign xl_w0 = (state == S_DOWN) ? w0_q : mem_rdata;

  umpvc_xlate u_xlate (
    .w0 (xl_w0),
    .w1 (mem_rdata),
    .xl (xl)
  );

  assign mt        = mem_rdata[31:28];
  assign slot_free = !out_valid || out_chan.ready;
  assign pass_last = (CW'(idx + 1'b1) == pkt_n);

  assign in_chan.ready    = (state == S_COLLECT);
  assign out_chan.valid    = out_valid;
  assign out_chan.out_word = out_word;
  assign out_chan.out_last = out_last;
  assign out_chan.status   = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_COLLECT;
      count     <= '0;
      ovf       <= 1'b0;
      pkt_n     <= '0;
      pkt_ovf   <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
      direction <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ovf       <= ovf_next;
      pkt_n     <= pkt_n_next;
      pkt_ovf   <= pkt_ovf_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        direction <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    w0_q       <= w0_next;
    out_word   <= out_word_next;
    out_last   <= out_last_next;
    out_status <= out_status_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    ovf_next        = ovf;
    pkt_n_next      = pkt_n;
    pkt_ovf_next    = pkt_ovf;
    idx_next        = idx;
    w0_next         = w0_q;
    out_valid_next  = out_valid;
    out_word_next   = out_word;
    out_last_next   = out_last;
    out_status_next = out_status;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    emit            = 1'b0;
    e_word          = 32'h0;
    e_last          = 1'b1;
    e_st            = ST_OK;

    if (out_valid && out_chan.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_COLLECT: begin
        if (in_chan.valid) begin
          if (!ovf && (count < CW'(MAX_PACKET_WORDS))) begin
            mem_we     = 1'b1;
            count_next = CW'(count + 1'b1);
          end else begin
            ovf_next = 1'b1;
          end
          if (in_chan.in_last) begin
            pkt_n_next   = count_next;
            pkt_ovf_next = ovf_next;
            count_next   = '0;
            ovf_next     = 1'b0;
            state_next   = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        mem_re     = 1'b1;
        state_next = S_JUDGE;
      end
      S_JUDGE: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = S_COLLECT;
          priority if (pkt_ovf) begin
            e_st = ST_OVERFLOW;
          end else if (mt == MT_UTILITY) begin
            if (pkt_n != CW'(1)) begin
              e_st = ST_COUNT;
            end else begin
              e_word = mem_rdata;
            end
          end else if (mt == MT_DATA64) begin
            if (pkt_n[0] || (pkt_n == '0)) begin
              e_st = ST_COUNT;
            end else if (32'(pkt_n) > RESULT_LIMIT) begin
              e_st = ST_OVERFLOW;
            end else begin
              e_word     = mem_rdata;
              e_last     = 1'b0;
              idx_next   = CW'(1);
              state_next = S_PRD;
            end
          end else if (!direction) begin
            if (mt != MT_M1_VOICE) begin
              e_st = ST_TYPE;
            end else if (pkt_n != CW'(1)) begin
              e_st = ST_COUNT;
            end else if (!xl.op_ok) begin
              e_st = ST_OPCODE;
            end else begin
              e_word     = xl.up_a;
              e_last     = 1'b0;
              state_next = S_UP2;
            end
          end else begin
            if (mt != MT_M2_VOICE) begin
              e_st = ST_TYPE;
            end else if (pkt_n != CW'(2)) begin
              e_st = ST_COUNT;
            end else begin
              // opcode is judged once the second word is back
              emit       = 1'b0;
              w0_next    = mem_rdata;
              state_next = S_DRD;
            end
          end
        end
      end
      S_UP2: begin
        if (slot_free) begin
          emit       = 1'b1;
          e_word     = xl.up_b;
          state_next = S_COLLECT;
        end
      end
      S_DRD: begin
        mem_re     = 1'b1;
        mem_raddr  = AW'(1);
        state_next = S_DOWN;
      end
      S_DOWN: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = S_COLLECT;
          if (!xl.op_ok) begin
            e_st = ST_OPCODE;
          end else begin
            e_word = xl.down_a;
          end
        end
      end
      S_PRD: begin
        mem_re     = 1'b1;
        mem_raddr  = idx[AW-1:0];
        state_next = S_POUT;
      end
      S_POUT: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_word = mem_rdata;
          e_last = pass_last;
          if (pass_last) begin
            state_next = S_COLLECT;
          end else begin
            idx_next   = CW'(idx + 1'b1);
            state_next = S_PRD;
          end
        end
      end
      default: begin
        state_next = S_COLLECT;
      end
    endcase

    if (emit) begin
      out_valid_next  = 1'b1;
      out_word_next   = e_word;
      out_last_next   = e_last;
      out_status_next = e_st;
    end
  end

endmodule

// ----- hdl/umpvc_chk.sv -----
// port-level checker for the ump voice converter, bound to the top level
`include "ump_midi1_midi2_voice_converter_core_assert.svh"

module umpvc_chk import umpvc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic        out_last,
  input logic [2:0]  out_status
);

  // a fault is a single zero word that closes the packet
  `UMPVC_ASSERT_NOW(a_fault_closes, clk, rst, out_valid && (out_status != ST_OK), out_last && (out_word == 32'h0), "fault result must be a last zero word")

  // no new words while a packet is still being answered
  `UMPVC_ASSERT_NOW(a_no_take_mid_answer, clk, rst, out_valid && !out_last, !in_ready, "input taken while answer is incomplete")

  // the last word hands control to the answer sequence
  `UMPVC_ASSERT_NXT(a_last_stops_input, clk, rst, in_valid && in_ready && in_last, !in_ready, "input still open after last word")

  `UMPVC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word) && $stable(out_last) && $stable(out_status), "stalled result changed")

endmodule

bind ump_midi1_midi2_voice_converter_core umpvc_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_last    (in_chan.in_last),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_word   (out_chan.out_word),
  .out_last   (out_chan.out_last),
  .out_status (out_chan.status)
);
